// ----- rtl/core/bbl_pkg.sv -----
// ----------------------------------------------------------------------------
// bbl_pkg - shared types and constants for the clamped-edge line box blur
// Pixel layout, window cell control and reciprocal format.
// ----------------------------------------------------------------------------
package bbl_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int PIX_W       = CH_W * NUM_CH;
    localparam int IDX_W       = 8;    // cell index, covers 2 * 127
    localparam int RAD_REG_W   = 6;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef logic [PIX_W-1:0] pixel_t;

    // window step command broadcast along the cell chain
    typedef struct packed {
        logic             step;      // advance the window this cycle
        logic             load_all;  // line start: every cell takes the new pixel
        logic [IDX_W-1:0] ins_idx;   // cell that takes the new pixel (2r)
    } cell_ctrl_t;

endpackage

// ----- rtl/core/box_blur_line_clamped_edge.sv -----
// ----------------------------------------------------------------------------
// box_blur_line_clamped_edge - RGBA line box blur, edges clamped
// Running per-channel window sums over a chain of pixel cells, rounded mean.
// ----------------------------------------------------------------------------
//  channel   signals                           request carries
//  --------  --------------------------------  --------------------------------
//  s_        tvalid tready tdata tlast         one pixel; tlast = last_in_line
//  m_        tvalid tready tdata tlast tuser   one mean; tlast = run_last,
//                                              tuser = line_end
//  cfg_      valid ready data                  blur_radius
//
//  One pixel is taken per cycle inside a line unless the output stalls. The last
//  pixel of a line starts a flush of r further steps, during which no input is
//  taken. A result reaches m_ through the sum registers, then the reciprocal
//  multiply register, then the correction register.
//  A stall on the output freezes the whole pipe and input together.
//  Reset clears the counters, sums and valid flags; the window cells are
//  loaded from the first pixel of every line and carry no reset.
// ----------------------------------------------------------------------------
module box_blur_line_clamped_edge #(
    parameter int MAX_RADIUS = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bbl_pkg::PIX_W-1:0]      s_tdata,   // in_blue, in_green, in_red, in_alpha
    input  logic                           s_tlast,   // last_in_line
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bbl_pkg::PIX_W-1:0]      m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic                           m_tlast,   // run_last
    output logic [0:0]                     m_tuser,   // line_end
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbl_pkg::RAD_REG_W-1:0]  cfg_data   // blur_radius
);
    import bbl_pkg::*;

    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int DIAM_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(DEPTH * 255 + MAX_RADIUS + 1);
    localparam int POS_W  = 7;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // reciprocal of the diameter, floor(2^16 / (2r + 1)), one per radius
    logic [RECIP_W-1:0] recip_tab [MAX_RADIUS+1];

    for (genvar g = 0; g <= MAX_RADIUS; g++)
    begin : g_recip
        localparam logic [RECIP_W-1:0] RV = RECIP_W'((1 << RECIP_SHIFT) / (2 * g + 1));
        assign recip_tab[g] = RV;
    end

    // configuration
    logic [RAD_REG_W-1:0] radius_reg;
    logic [RW-1:0]        r;
    logic [DIAM_W-1:0]    diam;

    assign cfg_ready = 1'b1;
    assign r    = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign diam = DIAM_W'({r, 1'b1});

    // control state
    logic              flushing_reg;
    logic [RW-1:0]     flush_rem_reg;
    logic [RW-1:0]     skip_reg;
    logic [POS_W-1:0]  pos_reg;
    pixel_t            last_px_reg;

    logic              en;
    logic              take;
    logic              step;
    logic              line_start;
    logic              emit;
    logic              fin;
    logic              run_last;
    pixel_t            v;
    logic              p_ge_r;

    // pipe advances whenever the output slot is free or being emptied
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !flushing_reg;
    assign take     = s_tvalid && s_tready;
    assign step     = take || (flushing_reg && en);
    assign v        = flushing_reg ? last_px_reg : s_tdata;
    assign line_start = take && (pos_reg == '0);
    assign p_ge_r   = (8'(pos_reg) >= 8'(r));

    always_comb
    begin
        if (flushing_reg)
        begin
            emit     = (skip_reg == '0);
            fin      = (flush_rem_reg == RW'(1));
            run_last = fin;
        end
        else
        begin
            emit     = p_ge_r;
            fin      = s_tlast && (r == '0);
            run_last = !s_tlast || fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RAD_REG_W'(1);
            flushing_reg  <= 1'b0;
            flush_rem_reg <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                radius_reg <= cfg_data;
            end
            if (take)
            begin
                if (s_tlast)
                begin
                    pos_reg       <= '0;
                    flushing_reg  <= (r != '0);
                    flush_rem_reg <= r;
                    // flush steps whose centre still lies before the line start
                    skip_reg      <= p_ge_r ? '0 : RW'(8'(r) - 8'(pos_reg) - 8'(1));
                end
                else if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            else if (flushing_reg && en)
            begin
                flush_rem_reg <= flush_rem_reg - RW'(1);
                flushing_reg  <= !fin;
                if (skip_reg != '0)
                begin
                    skip_reg <= skip_reg - RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_px_reg <= s_tdata;
        end
    end

    // window chain: cell 0 holds the oldest pixel, new pixels enter at 2r
    cell_ctrl_t ctrl;
    pixel_t     cell_px [DEPTH];

    assign ctrl.step     = step;
    assign ctrl.load_all = line_start;
    assign ctrl.ins_idx  = IDX_W'({r, 1'b0});

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        pixel_t up;
        if (k == DEPTH - 1)
        begin : g_top
            assign up = v;
        end
        else
        begin : g_mid
            assign up = cell_px[k+1];
        end
        bbl_cell #(.CELL_IDX(k)) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .new_px  (v),
            .from_up (up),
            .px      (cell_px[k])
        );
    end

    // running channel sums
    logic [SUM_W-1:0] sum_reg  [NUM_CH];
    logic [SUM_W-1:0] sum_next [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (line_start)
            begin
                sum_next[c] = SUM_W'(v[c*CH_W +: CH_W]) * SUM_W'(diam);
            end
            else
            begin
                sum_next[c] = sum_reg[c] + SUM_W'(v[c*CH_W +: CH_W])
                            - SUM_W'(cell_px[0][c*CH_W +: CH_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (step)
        begin
            sum_reg <= sum_next;
        end
    end

    // result flags travel beside the divider
    logic [2:0] vld_reg;
    logic [2:0] end_reg;
    logic [2:0] rl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            end_reg <= '0;
            rl_reg  <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], step && emit};
            end_reg <= {end_reg[1:0], fin};
            rl_reg  <= {rl_reg[1:0], run_last};
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_div
        bbl_div #(.NUM_W(SUM_W), .DIAM_W(DIAM_W)) u_div (
            .clk   (clk),
            .en    (en),
            .num   (sum_reg[c] + SUM_W'(r)),
            .recip (recip_tab[r]),
            .diam  (diam),
            .quo   (m_tdata[c*CH_W +: CH_W])
        );
    end

    assign m_tvalid   = vld_reg[2];
    assign m_tlast    = rl_reg[2];
    assign m_tuser[0] = end_reg[2];

endmodule

// ----- rtl/core/bbl_cell.sv -----
// ----------------------------------------------------------------------------
// bbl_cell - one pixel cell of the blur window chain
// Holds one pixel; takes its upper neighbour's pixel or the new one per step.
// ----------------------------------------------------------------------------
module bbl_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  bbl_pkg::cell_ctrl_t ctrl,
    input  bbl_pkg::pixel_t     new_px,
    input  bbl_pkg::pixel_t     from_up,
    output bbl_pkg::pixel_t     px
);
    import bbl_pkg::*;

    pixel_t px_reg;
    pixel_t px_next;

    always_comb
    begin
        if (ctrl.load_all || (ctrl.ins_idx == IDX_W'(CELL_IDX)))
        begin
            px_next = new_px;
        end
        else
        begin
            px_next = from_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            px_reg <= px_next;
        end
    end

    assign px = px_reg;

endmodule

// ----- rtl/core/bbl_div.sv -----
// ----------------------------------------------------------------------------
// bbl_div - two-stage divide of a window sum by the window diameter
// Reciprocal multiply, then one multiply-back and a single correction.
// ----------------------------------------------------------------------------
module bbl_div #(
    parameter int NUM_W  = 16,
    parameter int DIAM_W = 7
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NUM_W-1:0]            num,
    input  logic [bbl_pkg::RECIP_W-1:0] recip,
    input  logic [DIAM_W-1:0]           diam,
    output logic [bbl_pkg::CH_W-1:0]    quo
);
    import bbl_pkg::*;

    logic [NUM_W+RECIP_W-1:0] prod_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIAM_W-1:0]        diam_reg;
    logic [CH_W-1:0]          quo_reg;
    logic [CH_W-1:0]          est;
    logic [NUM_W-1:0]         rem;

    // estimate is the true quotient or one below it
    assign est = prod_reg[RECIP_SHIFT +: CH_W];
    assign rem = num_reg - NUM_W'(est * diam_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(recip);
            num_reg  <= num;
            diam_reg <= diam;
            quo_reg  <= (rem >= NUM_W'(diam_reg)) ? est + CH_W'(1) : est;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench for the clamped-edge line box blur
// Drives lines of random RGBA pixels through several radii with random idling
// on both streams, predicts every window mean and checks results in order.
// ----------------------------------------------------------------------------

// scoreboard: keeps its own copy of the line state and the expected means
class blur_scoreboard;
    localparam int MAXR  = 50;
    localparam int DEPTH = 2 * MAXR + 1;

    logic [31:0] window_px [DEPTH];
    logic [31:0] line_first;
    int unsigned line_pos;
    int unsigned wr_ptr;
    int unsigned radius;
    logic [33:0] pending_means [$];   // {line_end, run_last, pixel}
    int          mismatches;

    function new();
        foreach (window_px[i]) window_px[i] = '0;
        line_first = '0;
        line_pos   = 0;
        wr_ptr     = 0;
        radius     = 1;
        mismatches = 0;
    endfunction

    function void set_radius(logic [5:0] value);
        radius = value;
    endfunction

    // mean of the window centred d pixels behind the newest one
    function logic [31:0] window_mean(int unsigned d, int unsigned r, int unsigned p);
        int unsigned acc [4];
        int          age;
        logic [31:0] px;
        logic [31:0] res;
        acc = '{0, 0, 0, 0};
        for (int k = -int'(r); k <= int'(r); k++)
        begin
            age = int'(d) - k;
            if (age < 0)
                age = 0;
            if (age > int'(p))
                px = line_first;
            else
                px = window_px[(wr_ptr + DEPTH - age) % DEPTH];
            for (int c = 0; c < 4; c++)
                acc[c] += px[8*c +: 8];
        end
        for (int c = 0; c < 4; c++)
            res[8*c +: 8] = 8'((acc[c] + r) / (2 * r + 1));
        return res;
    endfunction

    function void note_pixel(logic [31:0] px, logic last);
        int unsigned r;
        int unsigned p;
        int unsigned dmax;
        r = (radius > MAXR) ? MAXR : radius;
        p = line_pos;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        window_px[wr_ptr] = px;
        if (p == 0)
            line_first = px;
        if (last)
        begin
            dmax = (p < r) ? p : r;
            for (int d = int'(dmax); d >= 0; d--)
                pending_means.push_back({d == 0, d == 0, window_mean(d, r, p)});
            line_pos = 0;
        end
        else
        begin
            if (p >= r)
                pending_means.push_back({1'b0, 1'b1, window_mean(r, r, p)});
            line_pos = (p >= 127) ? 127 : p + 1;
        end
    endfunction

    function void check_mean(logic [31:0] data, logic run_last, logic line_end);
        logic [33:0] want;
        if (pending_means.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result data=%h last=%b user=%b",
                         data, run_last, line_end);
            return;
        end
        want = pending_means.pop_front();
        if (want !== {line_end, run_last, data})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want data=%h last=%b end=%b, got data=%h last=%b end=%b",
                         want[31:0], want[32], want[33], data, run_last, line_end);
        end
    endfunction
endclass

module tb_top;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    blur_scoreboard means = new();

    int send_idle_pct = 28;    // sender idle share, percent
    int recv_idle_pct = 83;    // receiver idle share, percent
    int hold_cycles   = 0;     // long receiver hold-off, counted down

    always #4 clk = ~clk;

    box_blur_line_clamped_edge u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // receiver: random tready, plus a long hold-off when requested;
    // results are checked at the edge where the request completes
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            means.check_mean(m_tdata, m_tlast, m_tuser[0]);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one pixel, with random idle cycles before it;
    // tvalid stays high after the request so pixels can follow back to back
    task automatic send_pixel(logic [31:0] px, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        means.note_pixel(px, last);
    endtask

    // wait until idle, then write the radius
    task automatic write_radius(logic [5:0] value);
        s_tvalid <= 1'b0;
        while (means.pending_means.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        means.set_radius(value);
    endtask

    function automatic logic [31:0] rand_pixel();
        return $urandom();
    endfunction

    // one line of n pixels; mode 1 uses extreme channel values
    task automatic send_line(int n, int mode);
        logic [31:0] px;
        for (int i = 0; i < n; i++)
        begin
            if (mode == 1)
                px = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0000_0000;
            else
                px = rand_pixel();
            send_pixel(px, i == n - 1);
        end
    endtask

    initial
    begin
        logic [5:0] radii [6];
        int         n;
        radii = '{6'd1, 6'd0, 6'd63, 6'd50, 6'd3, 6'd17};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-pixel lines, extremes, reset radius
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_line(6, 1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h8040_20FF, 1'b1);
        write_radius(6'd0);      // pass-through
        send_line(4, 0);
        write_radius(6'd63);     // above the maximum, clamps to 50
        send_line(5, 1);

        // random part across three idling phases and several radii
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 28;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int j = 0; j < 6; j++)
            begin
                write_radius(radii[(phase * 2 + j) % 6]);
                if (phase == 2 && j == 1)
                    hold_cycles = 300;   // block fills and stalls input
                // one long line at the largest radius runs past position 127
                if (phase == 2 && j == 4)
                    n = 130;
                else
                    n = $urandom_range(5, 1);
                send_line(n, $urandom_range(4) == 0);
            end
        end

        s_tvalid <= 1'b0;
        while (means.pending_means.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (means.mismatches == 0 && means.pending_means.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/bbl_pkg.sv
rtl/core/bbl_cell.sv
rtl/core/bbl_div.sv
rtl/core/box_blur_line_clamped_edge.sv
tb/tb_top.sv
